### rtl/mtrr_pkg.sv
// Shared types and constants for the variable-range memory type lookup.
package mtrr_pkg;

  localparam int ADDR_W         = 52;
  localparam int FRAME_W        = 40;
  localparam int PAGE_W         = 18;
  localparam int TYPE_W         = 8;
  localparam int FRAME_SHIFT    = 12;
  localparam int BIG_PAGE_SHIFT = 21;

  localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

  // Memory type codes
  localparam logic [TYPE_W-1:0] TYPE_UC = 8'd0;
  localparam logic [TYPE_W-1:0] TYPE_WB = 8'd6;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Input word
  typedef struct packed {
    logic               action;
    logic [FRAME_W-1:0] base_frame;
    logic [FRAME_W-1:0] mask_frame;
    logic               mask_valid;
    logic [TYPE_W-1:0]  range_type;
    logic [PAGE_W-1:0]  page_frame;
  } mtrr_in_t;

  // Result word
  typedef struct packed {
    logic [TYPE_W-1:0] memory_type;
    logic              stored;
    logic              dropped;
  } mtrr_out_t;

  // One stored range
  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic [TYPE_W-1:0] kind;
  } mtrr_entry_t;

endpackage

### rtl/mtrr_range_memory_type_lookup.sv
// Top level: variable-range memory type table with a sequential 2MB page classifier.
//
// Usage:
//   Drive a word on item and raise start; the word is taken at a rising edge
//   where start is high and busy is low. Exactly one result word follows on
//   result, flagged by done for a single cycle. The receiver cannot stall, so
//   it must take the word in that cycle.
//   A load (action 0) that is disabled, write-back or hits a full table
//   answers in the cycle after acceptance; a storable load passes through
//   mask decode, then end address add and table write.
//   A query (action 1) of page zero or of an empty table answers in the cycle
//   after acceptance. Otherwise the stored ranges are read from the table memory
//   one per cycle through its single registered read port, in order, until the
//   last one is compared or an uncacheable match ends the walk early.
//   busy is high from acceptance until the result cycle (for a word not
//   answered from idle); a new word may be started in the cycle that done is high.
//   Synchronous reset empties the table (the range count goes to zero); the
//   table memory itself is not cleared since only filled entries are read.
module mtrr_range_memory_type_lookup
  import mtrr_pkg::*;
#(
  parameter int MAX_RANGES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  mtrr_in_t  item,
  output logic      busy,
  output logic      done,
  output mtrr_out_t result
);

  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MASK  = 4'b0010,
    S_WRITE = 4'b0100,
    S_WALK  = 4'b1000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  mtrr_in_t           cur;
  logic [FRAME_W-1:0] low_run;
  logic [CNT_W-1:0]   walk_cnt;
  logic               cmp_valid;
  logic               cmp_last;
  logic [TYPE_W-1:0]  kind_acc;

  logic               accept;
  logic               issue;
  logic               hit;
  logic               hit_uc;
  logic               walk_end;
  logic               full;
  logic               skip_load;
  logic               quick;
  mtrr_out_t          quick_word;
  logic [ADDR_W-1:0]  page_lo;
  logic [ADDR_W-1:0]  page_hi;
  logic [ADDR_W-1:0]  start_addr;
  logic [ADDR_W-1:0]  size_m1;
  logic [ADDR_W:0]    end_sum;
  mtrr_entry_t        wr_data;
  mtrr_entry_t        rd_data;
  logic               wr_en;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Words answered straight from the idle state, and their result
  assign full      = (count == CNT_W'(MAX_RANGES));
  assign skip_load = !item.mask_valid || (item.range_type == TYPE_WB);
  assign quick     = (item.action == ACT_LOAD) ? (skip_load || full)
                                               : ((item.page_frame == '0) || (count == '0));

  always_comb begin
    quick_word = '0;
    if (item.action == ACT_LOAD) begin
      quick_word.dropped = !skip_load && full;
    end else begin
      quick_word.memory_type = (item.page_frame == '0) ? TYPE_UC : TYPE_WB;
    end
  end

  // End address: size - 1 is the run of zeros below the lowest mask bit,
  // shifted up a frame; a zero mask gives all ones and saturates naturally.
  assign start_addr = {cur.base_frame, {FRAME_SHIFT{1'b0}}};
  assign size_m1    = {low_run, {FRAME_SHIFT{1'b1}}};
  assign end_sum    = {1'b0, start_addr} + {1'b0, size_m1};

  assign wr_en         = (state == S_WRITE);
  assign wr_data.first = start_addr;
  assign wr_data.last  = end_sum[ADDR_W] ? ADDR_TOP : end_sum[ADDR_W-1:0];
  assign wr_data.kind  = cur.range_type;

  // Page bounds and overlap check against the entry read last cycle
  assign page_lo = {{(ADDR_W-PAGE_W-BIG_PAGE_SHIFT){1'b0}}, cur.page_frame,
                    {BIG_PAGE_SHIFT{1'b0}}};
  assign page_hi = {{(ADDR_W-PAGE_W-BIG_PAGE_SHIFT){1'b0}}, cur.page_frame,
                    {BIG_PAGE_SHIFT{1'b1}}};
  assign hit     = cmp_valid && (page_lo <= rd_data.last) && (page_hi >= rd_data.first);
  assign hit_uc  = hit && (rd_data.kind == TYPE_UC);

  assign issue    = (state == S_WALK) && (walk_cnt != count);
  assign walk_end = hit_uc || (cmp_valid && cmp_last);

  mtrr_range_table #(
    .DEPTH (MAX_RANGES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (walk_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= accept && quick;
          if (accept) begin
            cur    <= item;
            result <= quick_word;
            if (!quick) begin
              if (item.action == ACT_LOAD) begin
                state <= S_MASK;
              end else begin
                walk_cnt  <= '0;
                cmp_valid <= 1'b0;
                kind_acc  <= TYPE_WB;
                state     <= S_WALK;
              end
            end
          end
        end
        S_MASK: begin
          done    <= 1'b0;
          low_run <= (cur.mask_frame - FRAME_W'(1)) & ~cur.mask_frame;
          state   <= S_WRITE;
        end
        S_WRITE: begin
          count         <= count + CNT_W'(1);
          result.stored <= 1'b1;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_WALK: begin
          cmp_valid <= issue && !walk_end;
          cmp_last  <= ((walk_cnt + CNT_W'(1)) == count);
          done      <= walk_end;
          if (issue) begin
            walk_cnt <= walk_cnt + CNT_W'(1);
          end
          if (hit) begin
            kind_acc <= rd_data.kind;
          end
          if (walk_end) begin
            result.memory_type <= hit ? rd_data.kind : kind_acc;
            state              <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result word without a preceding request");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.stored && result.dropped))
    else $error("load word both stored and dropped");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES))
    else $error("range count above table depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (walk_cnt < count))
    else $error("table read beyond filled entries");

  a_write_only_when_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count != CNT_W'(MAX_RANGES)))
    else $error("table write into a full table");

endmodule

### rtl/mtrr_range_table.sv
// Range table memory: one write port, one registered read port.
module mtrr_range_table
  import mtrr_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  mtrr_entry_t      wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output mtrr_entry_t      rd_data
);

  mtrr_entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### sim/mtrr_lookup_checker.sv
// Checker for the memory type lookup: predicts each result word and compares it.
`timescale 1ns / 1ps

module mtrr_lookup_checker
  import mtrr_pkg::*;
#(
  parameter int MAX_RANGES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  logic      done,
  input  mtrr_in_t  item,
  input  mtrr_out_t result,
  output int        errors,
  output int        pending
);

  // Shadow copy of the range table
  logic [ADDR_W-1:0] shadow_first [MAX_RANGES];
  logic [ADDR_W-1:0] shadow_last  [MAX_RANGES];
  logic [TYPE_W-1:0] shadow_kind  [MAX_RANGES];
  int                shadow_count;

  mtrr_out_t expected_words [$];

  // Apply one accepted word to the shadow table and return its result word
  function automatic mtrr_out_t resolve_word(mtrr_in_t w);
    mtrr_out_t   r;
    logic [63:0] first;
    logic [63:0] last;
    logic [63:0] lo;
    logic [63:0] hi;
    int          lb;
    r = '0;
    if (w.action == ACT_LOAD) begin
      if (w.mask_valid && w.range_type != TYPE_WB) begin
        if (shadow_count >= MAX_RANGES) begin
          r.dropped = 1'b1;
        end else begin
          first = 64'(w.base_frame) << FRAME_SHIFT;
          if (w.mask_frame == '0) begin
            last = 64'(ADDR_TOP);
          end else begin
            lb = 0;
            while (!w.mask_frame[lb]) lb++;
            last = first + ((64'd1 << (lb + FRAME_SHIFT)) - 64'd1);
            // range running past the address width saturates
            if (last > 64'(ADDR_TOP)) last = 64'(ADDR_TOP);
          end
          shadow_first[shadow_count] = first[ADDR_W-1:0];
          shadow_last[shadow_count]  = last[ADDR_W-1:0];
          shadow_kind[shadow_count]  = w.range_type;
          shadow_count++;
          r.stored = 1'b1;
        end
      end
    end else if (w.page_frame == '0) begin
      // page zero is always uncacheable
      r.memory_type = TYPE_UC;
    end else begin
      lo = 64'(w.page_frame) << BIG_PAGE_SHIFT;
      hi = lo + (64'd1 << BIG_PAGE_SHIFT) - 64'd1;
      r.memory_type = TYPE_WB;
      // last overlapping range wins, an uncacheable hit ends the walk
      for (int i = 0; i < shadow_count; i++) begin
        if (lo <= 64'(shadow_last[i]) && hi >= 64'(shadow_first[i])) begin
          r.memory_type = shadow_kind[i];
          if (shadow_kind[i] == TYPE_UC) break;
        end
      end
    end
    return r;
  endfunction

  // Result check first, then prediction of a word accepted at the same edge
  always @(posedge clk) begin
    mtrr_out_t want;
    if (rst) begin
      shadow_count = 0;
      expected_words.delete();
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result word with none expected: type %0d stored %0b dropped %0b",
                     $realtime, result.memory_type, result.stored, result.dropped);
        end else begin
          want = expected_words.pop_front();
          if (result.memory_type !== want.memory_type || result.stored !== want.stored ||
              result.dropped !== want.dropped) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: type exp %0d got %0d, stored exp %0b got %0b, %s%0b got %0b",
                       $realtime, want.memory_type, result.memory_type, want.stored,
                       result.stored, "dropped exp ", want.dropped, result.dropped);
          end
        end
      end
      if (start && !busy) expected_words.push_back(resolve_word(item));
    end
    pending = expected_words.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top for the memory type lookup: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import mtrr_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_WORDS = 1800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PAGE_FRAMES  = 512;  // 4K frames per 2MB page
  localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      done;
  mtrr_in_t  item;
  mtrr_out_t result;
  int        errors;
  int        pending;
  int        idle_cycles;

  mtrr_range_memory_type_lookup #(
    .MAX_RANGES(TABLE_DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  mtrr_lookup_checker #(
    .MAX_RANGES(TABLE_DEPTH)
  ) u_checker (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .item   (item),
    .result (result),
    .errors (errors),
    .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: cycles with neither an accepted word nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Idle gap after a word: mostly none or short, a few long
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mask frame whose lowest set bit is lb, random above it
  function automatic logic [FRAME_W-1:0] make_mask(int lb);
    logic [FRAME_W-1:0] m;
    m = FRAME_W'({$urandom, $urandom});
    m = m << lb;
    m[lb] = 1'b1;
    return m;
  endfunction

  // Load word; the unused page field carries noise
  function automatic mtrr_in_t load_word(logic [FRAME_W-1:0] base, logic [FRAME_W-1:0] mask,
                                         logic valid, logic [TYPE_W-1:0] kind);
    mtrr_in_t w;
    w.action     = ACT_LOAD;
    w.base_frame = base;
    w.mask_frame = mask;
    w.mask_valid = valid;
    w.range_type = kind;
    w.page_frame = PAGE_W'($urandom);
    return w;
  endfunction

  // Query word; the unused load fields carry noise
  function automatic mtrr_in_t query_word(logic [PAGE_W-1:0] page);
    mtrr_in_t w;
    w.action     = ACT_QUERY;
    w.base_frame = FRAME_W'({$urandom, $urandom});
    w.mask_frame = FRAME_W'({$urandom, $urandom});
    w.mask_valid = 1'($urandom);
    w.range_type = TYPE_W'($urandom);
    w.page_frame = page;
    return w;
  endfunction

  // Range inside the low pages that queries aim at
  function automatic mtrr_in_t near_range_word();
    logic [TYPE_W-1:0] kinds [6];
    logic [FRAME_W-1:0] base;
    kinds = '{8'd0, 8'd1, 8'd2, 8'd4, 8'd5, 8'd7};
    base  = FRAME_W'($urandom_range(1, 63) * PAGE_FRAMES + $urandom_range(0, PAGE_FRAMES - 1));
    return load_word(base, make_mask($urandom_range(0, 12)), 1'b1, kinds[$urandom_range(0, 5)]);
  endfunction

  // Present one word and hold it until taken, then idle for gap cycles
  task automatic send_word(mtrr_in_t w, int gap);
    item  <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    mtrr_in_t          w;
    logic [PAGE_W-1:0] page;
    int                sel;
    bit                quiet;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, page zero and no overlap
    send_word(query_word('0), pick_gap(0));
    send_word(query_word(18'd1), pick_gap(0));
    // disabled pair and write-back pair store nothing
    send_word(load_word(40'h200, 40'h200, 1'b0, TYPE_UC), pick_gap(0));
    send_word(load_word(40'h200, 40'h200, 1'b1, TYPE_WB), pick_gap(0));
    // uncacheable 2MB range over page one
    send_word(load_word(40'h200, 40'h200, 1'b1, TYPE_UC), pick_gap(0));
    send_word(query_word(18'd1), pick_gap(0));
    // zero mask covers the whole space
    send_word(load_word(40'h0, 40'h0, 1'b1, 8'd1), pick_gap(0));
    send_word(query_word(18'd2), pick_gap(0));
    // top base with a huge size runs past the address width
    send_word(load_word({FRAME_W{1'b1}}, 40'h80_0000_0000, 1'b1, 8'd5), pick_gap(0));
    // 4K range inside page two, widest type value
    send_word(load_word(40'h400, 40'h1, 1'b1, 8'hFF), pick_gap(0));
    send_word(query_word(18'd2), pick_gap(0));
    send_word(query_word(PAGE_MAX), pick_gap(0));
    // 4K range at the top page, all-ones mask
    send_word(load_word(FRAME_W'(PAGE_MAX) * PAGE_FRAMES, {FRAME_W{1'b1}}, 1'b1, 8'd4),
              pick_gap(0));
    send_word(query_word(PAGE_MAX), pick_gap(0));
    // fill the rest of the table, then a storable load into the full table
    repeat (TABLE_DEPTH - 5) send_word(near_range_word(), pick_gap(0));
    send_word(load_word(40'h600, 40'h200, 1'b1, 8'd1), pick_gap(0));
    send_word(query_word(18'd3), pick_gap(0));

    // Random: mostly queries walking the full table, loads as noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet = ((n / 150) % 4) == 3;
      sel   = $urandom_range(0, 99);
      if (sel < 30) begin
        w = load_word(FRAME_W'({$urandom, $urandom}),
                      ($urandom_range(0, 1) != 0) ? make_mask($urandom_range(0, FRAME_W - 1))
                                                  : FRAME_W'({$urandom, $urandom}),
                      1'($urandom),
                      ($urandom_range(0, 1) != 0) ? TYPE_W'($urandom)
                                                  : TYPE_W'($urandom_range(0, 7)));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 45) page = PAGE_W'($urandom_range(0, 70));
        else if (sel < 50) page = '0;
        else if (sel < 55) page = PAGE_MAX;
        else page = PAGE_W'($urandom);
        w = query_word(page);
      end
      send_word(w, pick_gap(quiet));
    end
    start <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
